// File: design/ffha_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and command codes of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

  localparam int HEAP_BYTES      = 4096;
  localparam int HEADER_BYTES    = 8;
  localparam int MIN_SPLIT_SLACK = 8;
  localparam int AW              = $clog2(HEAP_BYTES);

  // Request kinds
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_SIZE = 1'b1;

  // Datapath operations
  localparam logic [4:0] OP_NOP         = 5'd0;
  localparam logic [4:0] OP_LATCH       = 5'd1;
  localparam logic [4:0] OP_CLR         = 5'd2;
  localparam logic [4:0] OP_FMT         = 5'd3;
  localparam logic [4:0] OP_RD_FIRST    = 5'd4;
  localparam logic [4:0] OP_RD_FREE     = 5'd5;
  localparam logic [4:0] OP_HLOAD       = 5'd6;
  localparam logic [4:0] OP_HLOAD_MERGE = 5'd7;
  localparam logic [4:0] OP_WALK        = 5'd8;
  localparam logic [4:0] OP_MSTEP_CONT  = 5'd9;
  localparam logic [4:0] OP_MSTEP_CLR   = 5'd10;
  localparam logic [4:0] OP_RESUME      = 5'd11;
  localparam logic [4:0] OP_CLSTEP      = 5'd12;
  localparam logic [4:0] OP_CLLAST      = 5'd13;
  localparam logic [4:0] OP_SPLIT       = 5'd14;
  localparam logic [4:0] OP_HWR         = 5'd15;
  localparam logic [4:0] OP_FWR         = 5'd16;

  typedef struct packed {
    logic          mark;
    logic          free;
    logic          last;
    logic [AW-1:0] size;
    logic [AW-1:0] next;
  } hdr_t;

  typedef struct packed {
    logic [4:0] op;
    logic       load_out;
    logic [1:0] res_status;
    logic       res_data;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       formatted;
    logic       off_ok;
    logic       h_free;
    logic       h_fits;
    logic       h_last;
    logic       m_free;
    logic       m_stop;
    logic       m_fits;
    logic       p_is_fp;
    logic       do_split;
    logic       f_ok;
    logic       clr_last;
    logic       out_valid;
  } stat_t;

endpackage

// File: design/ffha_dp.sv
`timescale 1ns / 1ps
// Datapath of the heap allocator: header memory, walk registers, config and result.
// Depends on ffha_pkg; driven by ffha_ctrl through cmd_t, reports through stat_t.
module ffha_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::cmd_t      cmd,
  output ffha_pkg::stat_t     stat,
  input  logic [1:0]          in_kind,
  input  logic [15:0]         in_length,
  input  logic [15:0]         in_address,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_data_address,
  output logic [1:0]          out_status
);

  localparam int AW = ffha_pkg::AW;

  ffha_pkg::hdr_t mem [ffha_pkg::HEAP_BYTES];
  ffha_pkg::hdr_t rd_r;
  ffha_pkg::hdr_t h_r;
  ffha_pkg::hdr_t wdata;

  logic [1:0]    kind_r;
  logic [15:0]   len_r;
  logic [15:0]   addr_r;
  logic [15:0]   base_r;
  logic [12:0]   size_cfg_r;
  logic          formatted_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] dh_r;
  logic [AW:0]   acc_r;
  logic [AW-1:0] fp_r;
  logic [AW-1:0] fp_next_r;
  logic          fp_last_r;
  logic [AW-1:0] p_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic [1:0]    out_status_r;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          wen;
  logic [AW:0]   acc_new;
  logic [15:0]   off16;
  logic [16:0]   eff;
  logic [AW-1:0] first_size;
  logic [AW-1:0] nb;
  logic [AW-1:0] split_size;

  always_comb begin
    acc_new    = acc_r + {1'b0, rd_r.size} + (AW+1)'(ffha_pkg::HEADER_BYTES);
    off16      = addr_r - base_r - 16'(ffha_pkg::HEADER_BYTES);
    eff        = (17'(size_cfg_r) < 17'(ffha_pkg::HEAP_BYTES)) ? 17'(size_cfg_r)
                                                              : 17'(ffha_pkg::HEAP_BYTES);
    first_size = (eff > 17'(ffha_pkg::HEADER_BYTES))
                 ? AW'(eff - 17'(ffha_pkg::HEADER_BYTES)) : '0;
    nb         = dh_r + AW'(ffha_pkg::HEADER_BYTES) + len_r[AW-1:0];
    split_size = h_r.size - len_r[AW-1:0] - AW'(ffha_pkg::HEADER_BYTES);
  end

  always_comb begin
    stat.kind      = kind_r;
    stat.formatted = formatted_r;
    stat.off_ok    = {1'b0, off16} < 17'(ffha_pkg::HEAP_BYTES);
    stat.h_free    = rd_r.free;
    stat.h_fits    = 17'(rd_r.size) >= {1'b0, len_r};
    stat.h_last    = rd_r.last;
    stat.m_free    = rd_r.free;
    stat.m_fits    = 17'(acc_new) >= {1'b0, len_r};
    stat.m_stop    = rd_r.last | stat.m_fits;
    stat.p_is_fp   = p_r == fp_r;
    stat.do_split  = 17'(h_r.size) >= ({1'b0, len_r} +
                     17'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_SLACK));
    stat.f_ok      = rd_r.mark & ~rd_r.free & (rd_r.size != '0);
    stat.clr_last  = &clr_cnt_r;
    stat.out_valid = out_valid_r;
  end

  // Read address and write port selection
  always_comb begin
    raddr = '0;
    waddr = '0;
    wen   = 1'b0;
    wdata = '0;
    unique case (cmd.op)
      ffha_pkg::OP_RD_FREE: raddr = off16[AW-1:0];
      ffha_pkg::OP_HLOAD_MERGE, ffha_pkg::OP_WALK, ffha_pkg::OP_MSTEP_CONT:
        raddr = rd_r.next;
      ffha_pkg::OP_MSTEP_CLR, ffha_pkg::OP_RESUME: raddr = h_r.next;
      ffha_pkg::OP_CLR: begin
        wen   = 1'b1;
        waddr = clr_cnt_r;
      end
      ffha_pkg::OP_FMT: begin
        wen   = 1'b1;
        wdata = '{mark: 1'b1, free: 1'b1, last: 1'b1, size: first_size, next: '0};
      end
      ffha_pkg::OP_CLSTEP, ffha_pkg::OP_CLLAST: begin
        raddr      = rd_r.next;
        wen        = 1'b1;
        waddr      = p_r;
        wdata      = rd_r;
        wdata.mark = 1'b0;
      end
      ffha_pkg::OP_SPLIT: begin
        wen   = 1'b1;
        waddr = nb;
        wdata = '{mark: 1'b1, free: 1'b1, last: h_r.last, size: split_size, next: h_r.next};
      end
      ffha_pkg::OP_HWR: begin
        wen        = 1'b1;
        waddr      = dh_r;
        wdata      = h_r;
        wdata.free = 1'b0;
      end
      ffha_pkg::OP_FWR: begin
        wen        = 1'b1;
        waddr      = off16[AW-1:0];
        wdata      = rd_r;
        wdata.free = 1'b1;
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // Walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ffha_pkg::OP_LATCH: begin
        kind_r <= in_kind;
        len_r  <= in_length;
        addr_r <= in_address;
      end
      ffha_pkg::OP_RD_FIRST: dh_r <= '0;
      ffha_pkg::OP_HLOAD: h_r <= rd_r;
      ffha_pkg::OP_HLOAD_MERGE: begin
        h_r       <= rd_r;
        acc_r     <= {1'b0, rd_r.size};
        fp_r      <= dh_r;
        fp_next_r <= rd_r.next;
        fp_last_r <= rd_r.last;
      end
      ffha_pkg::OP_WALK: dh_r <= rd_r.next;
      ffha_pkg::OP_RESUME: dh_r <= h_r.next;
      ffha_pkg::OP_MSTEP_CONT, ffha_pkg::OP_MSTEP_CLR: begin
        fp_r      <= fp_next_r;
        acc_r     <= acc_new;
        fp_next_r <= rd_r.next;
        fp_last_r <= rd_r.last;
        if (cmd.op == ffha_pkg::OP_MSTEP_CLR) begin
          p_r <= h_r.next;
        end
      end
      ffha_pkg::OP_CLSTEP: p_r <= rd_r.next;
      ffha_pkg::OP_CLLAST: begin
        h_r.size <= acc_r[AW-1:0];
        h_r.next <= fp_next_r;
        h_r.last <= fp_last_r;
      end
      ffha_pkg::OP_SPLIT: begin
        h_r.size <= len_r[AW-1:0];
        h_r.next <= nb;
        h_r.last <= 1'b0;
      end
      default: ;
    endcase
  end

  // Control state: config, format flag, sweep counter, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      size_cfg_r   <= 13'(ffha_pkg::HEAP_BYTES);
      formatted_r  <= 1'b0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
      out_status_r <= ffha_pkg::ST_OK;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          ffha_pkg::CFG_HEAP_BASE: base_r     <= cfg_wr_data;
          ffha_pkg::CFG_HEAP_SIZE: size_cfg_r <= cfg_wr_data[12:0];
          default: ;
        endcase
      end
      if (cmd.op == ffha_pkg::OP_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.op == ffha_pkg::OP_FMT) begin
        formatted_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r  <= 1'b1;
        out_status_r <= cmd.res_status;
        out_data_r   <= cmd.res_data
                        ? base_r + 16'(dh_r) + 16'(ffha_pkg::HEADER_BYTES) : '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_address = out_data_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_hwr_formatted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ffha_pkg::OP_HWR |-> formatted_r)
    else $error("header write on unformatted heap");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !cmd.load_out) |=> $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule

// File: design/ffha_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the heap allocator: one request at a time through the header walk.
// Depends on ffha_pkg; drives ffha_dp through cmd_t.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  input  ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_HCHK   = 4'd3;
  localparam logic [3:0] S_MCHK   = 4'd4;
  localparam logic [3:0] S_CLWALK = 4'd5;
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_HWR    = 4'd7;
  localparam logic [3:0] S_FCHK   = 4'd8;
  localparam logic [3:0] S_FMT    = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       fmt_r, fmt_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic       res_data_r, res_data_nxt;

  always_comb begin
    state_nxt      = state_r;
    fmt_nxt        = fmt_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    cmd            = '{op: ffha_pkg::OP_NOP, load_out: 1'b0,
                       res_status: res_status_r, res_data: res_data_r};
    in_stall       = 1'b1;
    unique case (state_r)
      S_CLR: begin
        cmd.op = ffha_pkg::OP_CLR;
        if (stat.clr_last) begin
          state_nxt = fmt_r ? S_FMT : S_IDLE;
          fmt_nxt   = 1'b0;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op         = ffha_pkg::OP_LATCH;
          res_status_nxt = ffha_pkg::ST_OK;
          res_data_nxt   = 1'b0;
          state_nxt      = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.kind)
          ffha_pkg::KIND_FORMAT: begin
            fmt_nxt   = 1'b1;
            state_nxt = S_CLR;
          end
          ffha_pkg::KIND_ALLOC: begin
            if (stat.formatted) begin
              cmd.op    = ffha_pkg::OP_RD_FIRST;
              state_nxt = S_HCHK;
            end else begin
              res_status_nxt = ffha_pkg::ST_NO_SPACE;
              state_nxt      = S_RESP;
            end
          end
          ffha_pkg::KIND_FREE: begin
            if (stat.formatted && stat.off_ok) begin
              cmd.op    = ffha_pkg::OP_RD_FREE;
              state_nxt = S_FCHK;
            end else begin
              res_status_nxt = ffha_pkg::ST_BAD_FREE;
              state_nxt      = S_RESP;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_HCHK: begin
        if (stat.h_free && stat.h_fits) begin
          cmd.op    = ffha_pkg::OP_HLOAD;
          state_nxt = S_SPLIT;
        end else if (stat.h_last) begin
          res_status_nxt = ffha_pkg::ST_NO_SPACE;
          state_nxt      = S_RESP;
        end else if (stat.h_free) begin
          cmd.op    = ffha_pkg::OP_HLOAD_MERGE;
          state_nxt = S_MCHK;
        end else begin
          cmd.op    = ffha_pkg::OP_WALK;
        end
      end
      S_MCHK: begin
        if (!stat.m_free || (stat.m_stop && !stat.m_fits)) begin
          cmd.op    = ffha_pkg::OP_RESUME;
          state_nxt = S_HCHK;
        end else if (stat.m_fits) begin
          cmd.op    = ffha_pkg::OP_MSTEP_CLR;
          state_nxt = S_CLWALK;
        end else begin
          cmd.op    = ffha_pkg::OP_MSTEP_CONT;
        end
      end
      S_CLWALK: begin
        if (stat.p_is_fp) begin
          cmd.op    = ffha_pkg::OP_CLLAST;
          state_nxt = S_SPLIT;
        end else begin
          cmd.op    = ffha_pkg::OP_CLSTEP;
        end
      end
      S_SPLIT: begin
        if (stat.do_split) begin
          cmd.op = ffha_pkg::OP_SPLIT;
        end
        state_nxt = S_HWR;
      end
      S_HWR: begin
        cmd.op       = ffha_pkg::OP_HWR;
        res_data_nxt = 1'b1;
        state_nxt    = S_RESP;
      end
      S_FCHK: begin
        if (stat.f_ok) begin
          cmd.op = ffha_pkg::OP_FWR;
        end else begin
          res_status_nxt = ffha_pkg::ST_BAD_FREE;
        end
        state_nxt = S_RESP;
      end
      S_FMT: begin
        cmd.op    = ffha_pkg::OP_FMT;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      fmt_r        <= 1'b0;
      res_status_r <= ffha_pkg::ST_OK;
      res_data_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fmt_r        <= fmt_nxt;
      res_status_r <= res_status_nxt;
      res_data_r   <= res_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_DISP)
    else $error("accepted item not dispatched");
  a_hwr_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HWR |=> (state_r == S_RESP && res_data_r))
    else $error("allocation not answered with an address");
  a_fmt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FMT |-> $past(state_r) == S_CLR)
    else $error("format without clearing pass");
`endif

endmodule

// File: design/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// Allocate walks the headers in chain order, checks each free neighbour for a merge and
//   unmarks each absorbed header, and on success splits and writes the header; free checks
//   and writes one header; format runs a clearing pass of the header memory first.
// Throughput: one item at a time; the header memory walk (one read a cycle) sets the rate;
//   the next item is taken in the cycle after the result is loaded.
// Reset (synchronous, rst_n low): a clearing pass of the header memory runs
//   before the first item is taken; configuration writes are taken during it.
module first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_length,
  input  logic [15:0] in_address,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_data_address,
  output logic [1:0]  out_status
);

  // Command and status between sequencer and datapath
  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  // Sequencer: decode the item, walk the chain, hold the result until taken
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: header memory, merge and split arithmetic, output item register
  ffha_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_length        (in_length),
    .in_address       (in_address),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_address (out_data_address),
    .out_status       (out_status)
  );

endmodule

// File: verif/ffha_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the first-fit heap allocator: tracks config writes, predicts
// each result from its own heap model and compares. Depends on ffha_pkg.
module ffha_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_length,
  input  logic [15:0] in_address,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wr_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_data_address,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [15:0] data_address;
    logic [1:0]  status;
  } alloc_result_t;

  bit          hd_mark [ffha_pkg::HEAP_BYTES];
  bit          hd_free [ffha_pkg::HEAP_BYTES];
  bit          hd_last [ffha_pkg::HEAP_BYTES];
  int unsigned hd_size [ffha_pkg::HEAP_BYTES];
  int unsigned hd_next [ffha_pkg::HEAP_BYTES];
  bit          formatted;
  logic [15:0] base_q;
  logic [12:0] size_q;
  alloc_result_t awaited_q[$];

  function automatic void wipe_headers();
    for (int i = 0; i < ffha_pkg::HEAP_BYTES; i++) begin
      hd_mark[i] = 0; hd_free[i] = 0; hd_last[i] = 0;
      hd_size[i] = 0; hd_next[i] = 0;
    end
  endfunction

  function automatic void format_heap();
    int unsigned usable;
    usable = (int'(size_q) < ffha_pkg::HEAP_BYTES) ? int'(size_q) : ffha_pkg::HEAP_BYTES;
    wipe_headers();
    hd_mark[0] = 1; hd_free[0] = 1; hd_last[0] = 1;
    hd_size[0] = (usable > ffha_pkg::HEADER_BYTES) ? usable - ffha_pkg::HEADER_BYTES : 0;
    formatted = 1;
  endfunction

  // First-fit walk with forward coalescing of free neighbours.
  function automatic bit first_fit(int unsigned len, output int unsigned blk);
    int unsigned dh, acc, fp, p, nx, nb;
    bit stop;
    blk = 0;
    dh = 0;
    if (!formatted) return 0;
    for (int g = 0; g <= ffha_pkg::HEAP_BYTES; g++) begin
      if (hd_free[dh]) begin
        if (hd_size[dh] < len) begin
          if (hd_last[dh]) return 0;
          acc = hd_size[dh];
          fp = dh;
          for (int g2 = 0; g2 <= ffha_pkg::HEAP_BYTES; g2++) begin
            if (hd_last[fp] || acc >= len) break;
            nx = hd_next[fp] % ffha_pkg::HEAP_BYTES;
            if (!hd_free[nx]) break;
            fp = nx;
            acc += hd_size[fp] + ffha_pkg::HEADER_BYTES;
          end
          if (acc < len) begin
            // not enough even with every neighbour: leave them, move on
            dh = hd_next[dh] % ffha_pkg::HEAP_BYTES;
            continue;
          end
          p = hd_next[dh] % ffha_pkg::HEAP_BYTES;
          for (int g2 = 0; g2 <= ffha_pkg::HEAP_BYTES; g2++) begin
            stop = (p == fp);
            nx = hd_next[p] % ffha_pkg::HEAP_BYTES;
            hd_mark[p] = 0;
            if (stop) break;
            p = nx;
          end
          hd_size[dh] = acc;
          hd_next[dh] = hd_next[fp];
          hd_last[dh] = hd_last[fp];
        end
        if (hd_size[dh] >= len + ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_SLACK) begin
          nb = dh + ffha_pkg::HEADER_BYTES + len;
          if (nb < ffha_pkg::HEAP_BYTES) begin
            hd_mark[nb] = 1; hd_free[nb] = 1;
            hd_size[nb] = hd_size[dh] - len - ffha_pkg::HEADER_BYTES;
            hd_next[nb] = hd_next[dh];
            hd_last[nb] = hd_last[dh];
            hd_size[dh] = len;
            hd_next[dh] = nb;
            hd_last[dh] = 0;
          end
        end
        hd_free[dh] = 0;
        blk = dh;
        return 1;
      end
      if (hd_last[dh]) return 0;
      dh = hd_next[dh] % ffha_pkg::HEAP_BYTES;
    end
    return 0;
  endfunction

  function automatic bit release_block(logic [15:0] addr);
    logic [15:0] off;
    off = addr - base_q - 16'(ffha_pkg::HEADER_BYTES);
    if (!formatted || int'(off) >= ffha_pkg::HEAP_BYTES) return 0;
    if (!hd_mark[off] || hd_free[off] || hd_size[off] == 0) return 0;
    hd_free[off] = 1;
    return 1;
  endfunction

  function automatic alloc_result_t predict_result(logic [1:0] kind, logic [15:0] len,
                                                   logic [15:0] addr);
    alloc_result_t r;
    int unsigned blk;
    r.data_address = '0;
    r.status = ffha_pkg::ST_OK;
    case (kind)
      ffha_pkg::KIND_FORMAT: format_heap();
      ffha_pkg::KIND_ALLOC: begin
        if (first_fit(int'(len), blk))
          r.data_address = base_q + 16'(blk) + 16'(ffha_pkg::HEADER_BYTES);
        else r.status = ffha_pkg::ST_NO_SPACE;
      end
      ffha_pkg::KIND_FREE: if (!release_block(addr)) r.status = ffha_pkg::ST_BAD_FREE;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst_n) begin
      wipe_headers();
      formatted  = 0;
      base_q     = '0;
      size_q     = 13'd4096;
      fail_count = 0;
      awaited_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == ffha_pkg::CFG_HEAP_BASE) base_q = cfg_wr_data;
        else size_q = cfg_wr_data[12:0];
      end
      if (in_valid && !in_stall)
        awaited_q.push_back(predict_result(in_kind, in_length, in_address));
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("result with nothing awaited: data_address %h status %0d",
                 out_data_address, out_status);
          fail_count++;
        end else begin
          e = awaited_q.pop_front();
          if (out_data_address !== e.data_address) begin
            $error("data_address expected %h actual %h", e.data_address, out_data_address);
            fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            fail_count++;
          end
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

// File: verif/tb_first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// Testbench top for first_fit_heap_allocator_core: drives requests, config and
// back-pressure, gives the verdict. Depends on ffha_pkg and ffha_checker.
module tb_first_fit_heap_allocator_core;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 30000;   // cycles with no handshake at all

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_kind = ffha_pkg::KIND_FORMAT;
  logic [15:0] in_length = '0;
  logic [15:0] in_address = '0;
  logic        cfg_wr_en = 0;
  logic        cfg_index = ffha_pkg::CFG_HEAP_BASE;
  logic [15:0] cfg_wr_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_data_address;
  logic [1:0]  out_status;

  int fail_count;
  int pending;
  int idle_pct = 0;      // sender gap chance per cycle
  int stall_pct = 0;     // receiver stall chance per cycle
  bit hold_req = 0;      // ask the receiver for one long hold-off
  int hold_left = 0;
  int quiet = 0;
  logic [15:0] cur_base = '0;
  int unsigned cur_heap = 4096;
  logic [15:0] live_q[$];  // data addresses handed out and not yet freed

  always #5 clk = ~clk;

  first_fit_heap_allocator_core dut (.*);

  ffha_checker chk (.*);

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Keep successful allocations around so frees can hit real blocks.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_status == ffha_pkg::ST_OK &&
        out_data_address != 0)
      live_q.push_back(out_data_address);
  end

  // Watchdog: any accepted item on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[first_fit_heap_allocator_core] ERROR");
      $finish;
    end
  end

  // Offer one item and hold it until taken.
  task automatic offer(logic [1:0] kind, logic [15:0] len, logic [15:0] addr);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid = 1;
    in_kind = kind;
    in_length = len;
    in_address = addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  // Free a tracked block; optionally keep it listed so a double free follows.
  task automatic free_live(bit keep);
    int k;
    logic [15:0] a;
    k = $urandom_range(live_q.size() - 1);
    a = live_q[k];
    if (!keep) live_q.delete(k);
    offer(ffha_pkg::KIND_FREE, 16'($urandom), a);
  endtask

  task automatic format_heap();
    offer(ffha_pkg::KIND_FORMAT, 16'($urandom), 16'($urandom));
    live_q.delete();
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      r = $urandom_range(99);
      if (r < 70) offer(ffha_pkg::KIND_ALLOC, 16'($urandom_range(64)), 16'($urandom));
      else if (r < 92)
        offer(ffha_pkg::KIND_ALLOC, 16'($urandom_range(cur_heap)), 16'($urandom));
      else offer(ffha_pkg::KIND_ALLOC, 16'($urandom), 16'($urandom));
    end else if (r < 85 && live_q.size() > 0) begin
      free_live($urandom_range(9) == 0);
    end else if (r < 92) begin
      // stray addresses: near the heap or anywhere
      if ($urandom_range(1))
        offer(ffha_pkg::KIND_FREE, 16'($urandom),
              cur_base + 16'($urandom_range(cur_heap)));
      else offer(ffha_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
    end else if (r < 96) begin
      offer(KIND_UNUSED, 16'($urandom), 16'($urandom));
    end else begin
      format_heap();
    end
  endtask

  initial begin
    logic [15:0] bases[7] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 16'h0000, 16'hFFF8,
                              16'h0ABC};
    logic [15:0] sizes[7] = '{16'd4096, 16'd16, 16'd300, 16'd8191, 16'd0, 16'd4096,
                              16'd1000};
    int idles[7]  = '{0, 85, 0, 36, 0, 85, 36};
    int stalls[7] = '{0, 0, 85, 36, 0, 85, 36};

    repeat (11) @(negedge clk);
    rst_n = 1;

    // Directed: before any format, then edges of a freshly formatted heap.
    offer(ffha_pkg::KIND_ALLOC, 16'd8, 16'h0000);
    offer(ffha_pkg::KIND_FREE, 16'h0000, 16'd8);
    offer(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    format_heap();
    offer(ffha_pkg::KIND_ALLOC, 16'd4088, '0);            // exactly the whole heap
    offer(ffha_pkg::KIND_ALLOC, 16'd1, '0);               // nothing left
    drain();
    free_live(1);
    free_live(0);                                         // double free of the same block
    offer(ffha_pkg::KIND_ALLOC, 16'hFFFF, '0);            // oversized
    offer(ffha_pkg::KIND_ALLOC, 16'd0, '0);               // zero-size block, split off
    drain();
    free_live(0);                                         // zero size: invalid free
    offer(ffha_pkg::KIND_FREE, '0, 16'd20);               // no header at that offset
    offer(ffha_pkg::KIND_FREE, '0, 16'h0000);             // maps outside the heap
    offer(ffha_pkg::KIND_ALLOC, 16'd100, '0);
    offer(ffha_pkg::KIND_ALLOC, 16'd100, '0);
    offer(ffha_pkg::KIND_ALLOC, 16'd100, '0);
    offer(ffha_pkg::KIND_ALLOC, 16'd3900, '0);            // fails, remainder too small
    drain();
    offer(ffha_pkg::KIND_FREE, '0, live_q[1]);
    offer(ffha_pkg::KIND_FREE, '0, live_q[2]);
    offer(ffha_pkg::KIND_ALLOC, 16'd150, '0);             // absorbs the freed neighbour
    drain();
    offer(ffha_pkg::KIND_FREE, '0, live_q[3]);
    offer(ffha_pkg::KIND_ALLOC, 16'd4000, '0);            // merge still short
    offer(ffha_pkg::KIND_ALLOC, 16'd3700, '0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      idle_pct = 0;
      stall_pct = 0;
      write_cfg(ffha_pkg::CFG_HEAP_BASE, bases[ph]);
      write_cfg(ffha_pkg::CFG_HEAP_SIZE, sizes[ph]);
      cur_base = bases[ph];
      cur_heap = (int'(sizes[ph][12:0]) < ffha_pkg::HEAP_BYTES) ? int'(sizes[ph][12:0])
                                                               : ffha_pkg::HEAP_BYTES;
      live_q.delete();                           // old addresses no longer line up
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      format_heap();
      if (ph == 0) hold_req = 1;                 // fill the block while the output is held
      for (int n = 0; n < 135; n++) random_item();
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("[first_fit_heap_allocator_core] OK");
    else $display("[first_fit_heap_allocator_core] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
design/ffha_pkg.sv
design/ffha_dp.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator_core.sv
verif/ffha_checker.sv
verif/tb_first_fit_heap_allocator_core.sv
